// ===== design/gpat_pkg.sv =====
package gpat_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int VECTOR_FRAC_BITS_DEF = 16;
    localparam int TABLE_LEN = 30;
    localparam longint GAIN_Q30 = 64'sd652032874;

    // Centidegree angles and CORDIC angle accumulators (centidegrees << 16).
    localparam int CDEG_W = 18;
    localparam int ANG_W = 36;
    localparam int OUT_W = 15;

    typedef logic signed [ANG_W-1:0] t_ang;

    // atan(2^-i) in centidegrees scaled by 2^16, rounded to nearest.
    function automatic t_ang atan_entry(input int idx);
        t_ang v;
        v = '0;
        unique case (idx)
            0:  v = 36'sd294912000;
            1:  v = 36'sd174096719;
            2:  v = 36'sd91987925;
            3:  v = 36'sd46694507;
            4:  v = 36'sd23437865;
            5:  v = 36'sd11730358;
            6:  v = 36'sd5866610;
            7:  v = 36'sd2933484;
            8:  v = 36'sd1466764;
            9:  v = 36'sd733385;
            10: v = 36'sd366693;
            11: v = 36'sd183346;
            12: v = 36'sd91673;
            13: v = 36'sd45837;
            14: v = 36'sd22918;
            15: v = 36'sd11459;
            16: v = 36'sd5730;
            17: v = 36'sd2865;
            18: v = 36'sd1432;
            19: v = 36'sd716;
            20: v = 36'sd358;
            21: v = 36'sd179;
            22: v = 36'sd90;
            23: v = 36'sd45;
            24: v = 36'sd22;
            25: v = 36'sd11;
            26: v = 36'sd6;
            27: v = 36'sd3;
            28: v = 36'sd1;
            29: v = 36'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/gpat_rot_cell.sv =====
// One rotation-mode CORDIC step for six independent sine/cosine lanes.
module gpat_rot_cell #(
    parameter int STEP = 0,
    parameter int VW = 24,
    parameter int NL = 6
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [NL-1:0][VW-1:0]         i_x,
    input  logic signed [NL-1:0][VW-1:0]         i_y,
    input  logic signed [NL-1:0][gpat_pkg::ANG_W-1:0] i_z,
    input  logic [NL-1:0]                        i_neg,
    output logic signed [NL-1:0][VW-1:0]         o_x,
    output logic signed [NL-1:0][VW-1:0]         o_y,
    output logic signed [NL-1:0][gpat_pkg::ANG_W-1:0] o_z,
    output logic [NL-1:0]                        o_neg
);
    import gpat_pkg::*;

    localparam t_ang ATAN_I = atan_entry(STEP);

    logic signed [NL-1:0][VW-1:0]    n_x, n_y;
    logic signed [NL-1:0][ANG_W-1:0] n_z;
    logic signed [VW-1:0]            sx, sy;

    always_comb begin
        n_x = i_x;
        n_y = i_y;
        n_z = i_z;
        sx  = '0;
        sy  = '0;
        for (int l = 0; l < NL; l++) begin
            sx = $signed(i_x[l]) >>> STEP;
            sy = $signed(i_y[l]) >>> STEP;
            if (!i_z[l][ANG_W-1]) begin
                n_x[l] = $signed(i_x[l]) - sy;
                n_y[l] = $signed(i_y[l]) + sx;
                n_z[l] = $signed(i_z[l]) - ATAN_I;
            end else begin
                n_x[l] = $signed(i_x[l]) + sy;
                n_y[l] = $signed(i_y[l]) - sx;
                n_z[l] = $signed(i_z[l]) + ATAN_I;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_x   <= n_x;
            o_y   <= n_y;
            o_z   <= n_z;
            o_neg <= i_neg;
        end
    end
endmodule

// ===== design/gpat_vec_cell.sv =====
// One vectoring-mode CORDIC step with side data carried along.
module gpat_vec_cell #(
    parameter int STEP = 0,
    parameter int VW = 24,
    parameter int SW = 8
) (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic signed [VW-1:0]              i_x,
    input  logic signed [VW-1:0]              i_y,
    input  logic signed [gpat_pkg::ANG_W-1:0] i_z,
    input  logic [SW-1:0]                     i_side,
    output logic signed [VW-1:0]              o_x,
    output logic signed [VW-1:0]              o_y,
    output logic signed [gpat_pkg::ANG_W-1:0] o_z,
    output logic [SW-1:0]                     o_side
);
    import gpat_pkg::*;

    localparam t_ang ATAN_I = atan_entry(STEP);

    logic signed [VW-1:0] sx, sy;

    assign sx = i_x >>> STEP;
    assign sy = i_y >>> STEP;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[VW-1]) begin
                o_x <= i_x + sy;
                o_y <= i_y - sx;
                o_z <= i_z + ATAN_I;
            end else begin
                o_x <= i_x - sy;
                o_y <= i_y + sx;
                o_z <= i_z - ATAN_I;
            end
            o_side <= i_side;
        end
    end
endmodule

// ===== design/gimbal_pointing_angle_transform.sv =====
// Channel | Direction | Handshake           | Payload
// in      | input     | i_valid / o_stall   | yaw, pitch, roll, axis az, mirror el
// out     | output    | o_valid / i_stall   | space az, space el, y zero flag
//
// One beat is accepted per clock while the output is not stalled; every beat
// gives exactly one result beat. The stages in order are range reduction, the
// rotation cell row, sign fix, six matrix stages, the azimuth vectoring row,
// azimuth finish, the elevation vectoring row and the output register.
// The whole pipeline advances only when the output register is free or is
// being taken, so a stall on the output freezes every stage in place.
// Reset (i_rst_n low, synchronous) clears only the valid bits of the stages.
module gimbal_pointing_angle_transform #(
    parameter int CORDIC_STEPS = gpat_pkg::CORDIC_STEPS_DEF,
    parameter int VECTOR_FRAC_BITS = gpat_pkg::VECTOR_FRAC_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic signed [15:0]         i_yaw_cdeg,
    input  logic signed [14:0]         i_pitch_cdeg,
    input  logic signed [15:0]         i_roll_cdeg,
    input  logic signed [16:0]         i_axis_az_cdeg,
    input  logic signed [14:0]         i_mirror_el_cdeg,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic signed [14:0]         o_space_az_cdeg,
    output logic signed [14:0]         o_space_el_cdeg,
    output logic                       o_y_zero_flag
);
    import gpat_pkg::*;

    // Number of CORDIC steps actually run.
    localparam int NS = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int F  = VECTOR_FRAC_BITS;
    // Vector word: unit values with headroom for CORDIC growth and sums.
    localparam int VW = F + 6;
    localparam int PW = 2 * VW;
    localparam int NL = 6;
    // Stage count: 1 reduce, NS rotate, 1 sign fix, 6 matrix (the last one
    // sets up azimuth vectoring), NS azimuth, 1 azimuth finish, NS elevation,
    // 1 output register.
    localparam int MS = 6;
    localparam int NSTG = 1 + NS + 1 + MS + NS + 1 + NS + 1;
    localparam longint GAIN_L = GAIN_Q30 >>> (30 - F);
    localparam logic signed [VW-1:0] GAIN_V = VW'(GAIN_L);

    // The whole pipeline moves as one; a free or draining output lets it move.
    logic adv;
    logic [NSTG-1:0] r_vld;
    assign adv     = !o_valid || !i_stall;
    assign o_stall = !adv;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Every data register below updates only under adv.
    // ---- Stage 0: range reduction of the six angles.
    function automatic logic signed [CDEG_W-1:0] wrap(input logic signed [CDEG_W+1:0] a);
        logic signed [CDEG_W+1:0] m;
        m = a;
        // Inputs lie within -65536..65535, so three conditional steps each way suffice.
        if (m >= 18000) m = m - (CDEG_W+2)'(36000);
        if (m >= 18000) m = m - (CDEG_W+2)'(36000);
        if (m >= 18000) m = m - (CDEG_W+2)'(36000);
        if (m < -18000) m = m + (CDEG_W+2)'(36000);
        if (m < -18000) m = m + (CDEG_W+2)'(36000);
        if (m < -18000) m = m + (CDEG_W+2)'(36000);
        return CDEG_W'(m);
    endfunction

    logic signed [NL-1:0][CDEG_W+1:0] raw;
    logic signed [NL-1:0][CDEG_W-1:0] wr, n_m0;
    logic [NL-1:0]                    n_neg0, r_neg0;
    logic signed [NL-1:0][ANG_W-1:0]  r_z0;

    always_comb begin
        raw[0] = (CDEG_W+2)'(i_axis_az_cdeg);
        raw[1] = 20'(i_mirror_el_cdeg) * 20'sd2 + 20'sd1500;
        raw[2] = 20'sd1500;
        raw[3] = (CDEG_W+2)'(i_yaw_cdeg);
        raw[4] = -(20'(i_pitch_cdeg));
        raw[5] = (CDEG_W+2)'(i_roll_cdeg);
    end

    // Angles beyond a quarter turn are folded back by half a turn and the
    // lane remembers to negate its sine and cosine.
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            wr[l]     = wrap(raw[l]);
            n_m0[l]   = wr[l];
            n_neg0[l] = 1'b0;
            if ($signed(wr[l]) > 9000) begin
                n_m0[l]   = $signed(wr[l]) - CDEG_W'(18000);
                n_neg0[l] = 1'b1;
            end else if ($signed(wr[l]) < -9000) begin
                n_m0[l]   = $signed(wr[l]) + CDEG_W'(18000);
                n_neg0[l] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < NL; l++) begin
                r_z0[l] <= ANG_W'($signed(n_m0[l])) <<< 16;
            end
            r_neg0 <= n_neg0;
        end
    end

    // ---- Rotation row: NS cells; the sign flags ride along inside the cells.
    logic signed [NS:0][NL-1:0][VW-1:0]    rx, ry;
    logic signed [NS:0][NL-1:0][ANG_W-1:0] rz;
    logic [NS:0][NL-1:0]                   rneg;

    assign rx[0]   = {NL{GAIN_V}};
    assign ry[0]   = '0;
    assign rz[0]   = r_z0;
    assign rneg[0] = r_neg0;

    for (genvar s = 0; s < NS; s++) begin : g_rot
        gpat_rot_cell #(.STEP(s), .VW(VW), .NL(NL)) u_cell (
            .i_clk (i_clk),
            .i_en  (adv),
            .i_x   (rx[s]),
            .i_y   (ry[s]),
            .i_z   (rz[s]),
            .i_neg (rneg[s]),
            .o_x   (rx[s+1]),
            .o_y   (ry[s+1]),
            .o_z   (rz[s+1]),
            .o_neg (rneg[s+1])
        );
    end

    // ---- Sign fix: sines and cosines.
    logic signed [NL-1:0][VW-1:0] r_s, r_c;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < NL; l++) begin
                r_s[l] <= rneg[NS][l] ? -ry[NS][l] : ry[NS][l];
                r_c[l] <= rneg[NS][l] ? -rx[NS][l] : rx[NS][l];
            end
        end
    end

    function automatic logic signed [VW-1:0] mf(input logic signed [VW-1:0] a,
                                                 input logic signed [VW-1:0] b);
        logic signed [PW-1:0] p;
        p = PW'(a) * PW'(b);
        return VW'(p >>> F);
    endfunction

    // Lane order: 0 az, 1 el, 2 tilt, 3 yaw, 4 pitch, 5 roll.
    // ---- Matrix stage 1: beam vector, pair products.
    logic signed [VW-1:0] r_u0, r_u1, r_u2, r_st, r_ct;
    logic signed [VW-1:0] r_sysp, r_cysp, r_cycr, r_sysr, r_sycr, r_cysr;
    logic signed [VW-1:0] r_sycp, r_cycp, r_cpsr, r_cpcr, r_sp1, r_sr1, r_cr1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_u0 <= mf(r_c[1], r_c[0]);
            r_u1 <= mf(r_c[1], r_s[0]);
            r_u2 <= r_s[1];
            r_st <= r_s[2];
            r_ct <= r_c[2];
            r_sysp <= mf(r_s[3], r_s[4]);
            r_cysp <= mf(r_c[3], r_s[4]);
            r_cycr <= mf(r_c[3], r_c[5]);
            r_sysr <= mf(r_s[3], r_s[5]);
            r_sycr <= mf(r_s[3], r_c[5]);
            r_cysr <= mf(r_c[3], r_s[5]);
            r_sycp <= mf(r_s[3], r_c[4]);
            r_cycp <= mf(r_c[3], r_c[4]);
            r_cpsr <= mf(r_c[4], r_s[5]);
            r_cpcr <= mf(r_c[4], r_c[5]);
            r_sp1 <= r_s[4];
            r_sr1 <= r_s[5];
            r_cr1 <= r_c[5];
        end
    end

    // ---- Matrix stage 2: tilt products and triple products.
    logic signed [VW-1:0] r_a0, r_a1, r_a2, r_a3, r_t0b;
    logic signed [VW-1:0] r_p1, r_p2, r_p3, r_p4;
    logic signed [VW-1:0] r_cycr2, r_sysr2, r_sycr2, r_cysr2, r_sycp2, r_cycp2;
    logic signed [VW-1:0] r_cpsr2, r_cpcr2, r_sp2;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a0 <= mf(r_ct, r_u0);
            r_a1 <= mf(r_st, r_u2);
            r_a2 <= mf(r_ct, r_u2);
            r_a3 <= mf(r_st, r_u0);
            r_t0b <= -r_u1;
            r_p1 <= mf(r_sysp, r_sr1);
            r_p2 <= mf(r_sysp, r_cr1);
            r_p3 <= mf(r_cysp, r_sr1);
            r_p4 <= mf(r_cysp, r_cr1);
            r_cycr2 <= r_cycr; r_sysr2 <= r_sysr; r_sycr2 <= r_sycr;
            r_cysr2 <= r_cysr; r_sycp2 <= r_sycp; r_cycp2 <= r_cycp;
            r_cpsr2 <= r_cpsr; r_cpcr2 <= r_cpcr; r_sp2 <= r_sp1;
        end
    end

    // ---- Matrix stage 3: rotated vector and matrix entries.
    logic signed [VW-1:0] r_t0, r_t1, r_t2;
    logic signed [VW-1:0] r_m00, r_m01, r_m02, r_m10, r_m11, r_m12, r_m20, r_m21, r_m22;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t0 <= r_t0b;
            r_t1 <= r_a0 + r_a1;
            r_t2 <= r_a2 - r_a3;
            r_m00 <= r_cycr2 + r_p1;
            r_m01 <= r_sycp2;
            r_m02 <= r_p2 - r_cysr2;
            r_m10 <= r_p3 - r_sycr2;
            r_m11 <= r_cycp2;
            r_m12 <= r_sysr2 + r_p4;
            r_m20 <= r_cpsr2;
            r_m21 <= -r_sp2;
            r_m22 <= r_cpcr2;
        end
    end

    // ---- Matrix stage 4: nine products.  (-sp*t1 == -(mf(sp,t1)) differs in
    // floor rounding, so the z middle term is formed as a product then negated.)
    logic signed [VW-1:0] r_q00, r_q01, r_q02, r_q10, r_q11, r_q12, r_q20, r_q21, r_q22;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q00 <= mf(r_m00, r_t0);
            r_q01 <= mf(r_m01, r_t1);
            r_q02 <= mf(r_m02, r_t2);
            r_q10 <= mf(r_m10, r_t0);
            r_q11 <= mf(r_m11, r_t1);
            r_q12 <= mf(r_m12, r_t2);
            r_q20 <= mf(r_m20, r_t0);
            r_q21 <= -mf(-r_m21, r_t1);
            r_q22 <= mf(r_m22, r_t2);
        end
    end

    // ---- Matrix stage 5: sums.
    logic signed [VW-1:0] r_x, r_y, r_z;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x <= r_q00 + r_q01 + r_q02;
            r_y <= r_q10 + r_q11 + r_q12;
            r_z <= r_q20 + r_q21 + r_q22;
        end
    end

    // ---- Matrix stage 6: azimuth vectoring setup.
    logic signed [VW-1:0] r_vx, r_vy, r_zc;
    logic r_yz, r_xneg;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_yz   <= (r_y == '0);
            r_xneg <= r_x[VW-1];
            r_vx   <= r_y[VW-1] ? -r_y : r_y;
            r_vy   <= r_y[VW-1] ? -r_x : r_x;
            r_zc   <= r_z;
        end
    end

    // ---- Azimuth vectoring row; side data: z, x (equal to the row's y input
    // when y is zero), flag, x sign.
    localparam int SA = 2 * VW + 2;
    logic signed [NS:0][VW-1:0]    ax, ay;
    logic signed [NS:0][ANG_W-1:0] az;
    logic [NS:0][SA-1:0]           aside;
    assign ax[0] = r_vx;
    assign ay[0] = r_vy;
    assign az[0] = '0;
    assign aside[0] = {r_zc, r_vy, r_yz, r_xneg};

    for (genvar s = 0; s < NS; s++) begin : g_az
        gpat_vec_cell #(.STEP(s), .VW(VW), .SW(SA)) u_cell (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_x    (ax[s]),
            .i_y    (ay[s]),
            .i_z    (az[s]),
            .i_side (aside[s]),
            .o_x    (ax[s+1]),
            .o_y    (ay[s+1]),
            .o_z    (az[s+1]),
            .o_side (aside[s+1])
        );
    end

    function automatic logic signed [OUT_W-1:0] rnd(input logic signed [ANG_W-1:0] z);
        logic signed [ANG_W-1:0] r;
        r = (z + 36'sd32768) >>> 16;
        if (r > 9000) r = ANG_W'(9000);
        if (r < -9000) r = -ANG_W'(9000);
        return OUT_W'(r);
    endfunction

    // ---- Azimuth finish and elevation setup.
    logic signed [VW-1:0]    hx;
    logic signed [VW-1:0]    r_mag, r_ez;
    logic signed [OUT_W-1:0] r_oaz;
    logic                    r_flag;
    assign hx = aside[NS][VW+1:2];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ez   <= aside[NS][SA-1:VW+2];
            r_flag <= aside[NS][1];
            if (aside[NS][1]) begin
                // y is zero: the azimuth saturates and the magnitude is |x|.
                r_oaz <= aside[NS][0] ? -OUT_W'(9000) : OUT_W'(9000);
                r_mag <= aside[NS][0] ? -hx : hx;
            end else begin
                r_oaz <= rnd(az[NS]);
                r_mag <= mf(ax[NS], GAIN_V);
            end
        end
    end

    // ---- Elevation vectoring row; side data: azimuth, flag, zero magnitude, z sign.
    localparam int SE = OUT_W + 3;
    logic signed [NS:0][VW-1:0]    ex, ey;
    logic signed [NS:0][ANG_W-1:0] ez;
    logic [NS:0][SE-1:0]           eside;
    assign ex[0] = r_mag;
    assign ey[0] = r_ez;
    assign ez[0] = '0;
    assign eside[0] = {r_oaz, r_flag, (r_mag == '0), r_ez[VW-1]};

    for (genvar s = 0; s < NS; s++) begin : g_el
        gpat_vec_cell #(.STEP(s), .VW(VW), .SW(SE)) u_cell (
            .i_clk  (i_clk),
            .i_en   (adv),
            .i_x    (ex[s]),
            .i_y    (ey[s]),
            .i_z    (ez[s]),
            .i_side (eside[s]),
            .o_x    (ex[s+1]),
            .o_y    (ey[s+1]),
            .o_z    (ez[s+1]),
            .o_side (eside[s+1])
        );
    end

    // ---- Output register.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_space_az_cdeg <= eside[NS][SE-1:3];
            o_y_zero_flag   <= eside[NS][2];
            if (eside[NS][1]) begin
                o_space_el_cdeg <= eside[NS][0] ? -OUT_W'(9000) : OUT_W'(9000);
            end else begin
                o_space_el_cdeg <= rnd(ez[NS]);
            end
        end
    end

    // Results stay inside the clamp range.
    a_az_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_space_az_cdeg <= 9000 && o_space_az_cdeg >= -9000))
        else $error("azimuth out of range");
    a_el_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_space_el_cdeg <= 9000 && o_space_el_cdeg >= -9000))
        else $error("elevation out of range");
    a_flag_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_y_zero_flag) |->
            (o_space_az_cdeg == 9000 || o_space_az_cdeg == -9000))
        else $error("flag without saturated azimuth");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_space_el_cdeg)))
        else $error("result lost under stall");
endmodule

// ===== tb/pointing_checker.sv =====
module pointing_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic signed [15:0] i_yaw_cdeg,
    input  logic signed [14:0] i_pitch_cdeg,
    input  logic signed [15:0] i_roll_cdeg,
    input  logic signed [16:0] i_axis_az_cdeg,
    input  logic signed [14:0] i_mirror_el_cdeg,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic signed [14:0] i_space_az_cdeg,
    input  logic signed [14:0] i_space_el_cdeg,
    input  logic               i_y_zero_flag,
    output int                 o_errors,
    output int                 o_pending
);

    localparam int STEPS = gpat_pkg::CORDIC_STEPS_DEF;
    localparam int FRAC  = gpat_pkg::VECTOR_FRAC_BITS_DEF;
    localparam int NTAB  = 30;

    typedef struct {
        logic signed [14:0] az;
        logic signed [14:0] el;
        logic               flag;
    } t_pointing;

    longint    arctan_q16 [NTAB] = '{
        294912000, 174096719, 91987925, 46694507, 23437865, 11730358,
        5866610, 2933484, 1466764, 733385, 366693, 183346, 91673, 45837,
        22918, 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45, 22, 11, 6, 3, 1, 1
    };
    t_pointing pointing_q[$];

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> FRAC;
    endfunction

    function automatic longint cordic_gain();
        return gpat_pkg::GAIN_Q30 >>> (30 - FRAC);
    endfunction

    function automatic void sine_cosine(input longint cdeg, output longint s,
                                        output longint c);
        longint m, x, y, z, nx;
        bit     flip;
        m = cdeg % 36000;
        flip = 0;
        if (m < 0) m += 36000;
        if (m >= 18000) m -= 36000;
        if (m > 9000) begin
            m -= 18000;
            flip = 1;
        end else if (m < -9000) begin
            m += 18000;
            flip = 1;
        end
        x = cordic_gain();
        y = 0;
        z = m * 65536;
        for (int i = 0; i < STEPS && i < NTAB; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_q16[i];
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_q16[i];
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    // Vectoring CORDIC: angle of (x, y) for x > 0, with the magnitude.
    function automatic longint vector_angle(input longint x, input longint y,
                                            output longint mag);
        longint z, nx, r;
        z = 0;
        for (int i = 0; i < STEPS && i < NTAB; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z += arctan_q16[i];
            end else begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z -= arctan_q16[i];
            end
            x = nx;
        end
        mag = qmul(x, cordic_gain());
        r = (z + 32768) >>> 16;
        if (r > 9000) r = 9000;
        if (r < -9000) r = -9000;
        return r;
    endfunction

    function automatic t_pointing predict_pointing(longint yaw, longint pit, longint rol,
                                                   longint az, longint mir);
        t_pointing res;
        longint sa, ca, se, ce, st, ct, sy, cy, sp, cp, sr, cr;
        longint u0, u1, u2, w0, w2, t0, t1, t2, x, y, z, mag, oaz, oel, m2;
        sine_cosine(az, sa, ca);
        sine_cosine(2 * mir + 1500, se, ce);
        sine_cosine(1500, st, ct);
        sine_cosine(yaw, sy, cy);
        sine_cosine(-pit, sp, cp);
        sine_cosine(rol, sr, cr);
        u0 = qmul(ce, ca);
        u1 = qmul(ce, sa);
        u2 = se;
        w0 = qmul(ct, u0) + qmul(st, u2);
        w2 = qmul(ct, u2) - qmul(st, u0);
        t0 = -u1;
        t1 = w0;
        t2 = w2;
        x = qmul(qmul(cy, cr) + qmul(qmul(sy, sp), sr), t0)
          + qmul(qmul(sy, cp), t1)
          + qmul(qmul(qmul(sy, sp), cr) - qmul(cy, sr), t2);
        y = qmul(qmul(qmul(cy, sp), sr) - qmul(sy, cr), t0)
          + qmul(qmul(cy, cp), t1)
          + qmul(qmul(sy, sr) + qmul(qmul(cy, sp), cr), t2);
        z = qmul(qmul(cp, sr), t0) - qmul(sp, t1) + qmul(qmul(cp, cr), t2);
        res.flag = 0;
        if (y == 0) begin
            res.flag = 1;
            oaz = (x >= 0) ? 9000 : -9000;
            mag = (x >= 0) ? x : -x;
        end else if (y > 0) begin
            oaz = vector_angle(y, x, mag);
        end else begin
            oaz = vector_angle(-y, -x, mag);
        end
        if (mag == 0) oel = (z >= 0) ? 9000 : -9000;
        else oel = vector_angle(mag, z, m2);
        res.az = oaz[14:0];
        res.el = oel[14:0];
        return res;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("MISMATCH at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_errors++;
    endtask

    initial o_errors = 0;
    initial o_pending = 0;

    always @(posedge i_clk) begin
        t_pointing want;
        if (i_rst_n && i_in_valid && !i_in_stall)
            pointing_q.push_back(predict_pointing(i_yaw_cdeg, i_pitch_cdeg, i_roll_cdeg,
                                                  i_axis_az_cdeg, i_mirror_el_cdeg));
        if (i_rst_n && i_out_valid && !i_out_stall) begin
            if (pointing_q.size() == 0) begin
                report("unexpected beat, space az", i_space_az_cdeg, 0);
            end else begin
                want = pointing_q.pop_front();
                if (i_space_az_cdeg !== want.az) report("space az", i_space_az_cdeg, want.az);
                if (i_space_el_cdeg !== want.el) report("space el", i_space_el_cdeg, want.el);
                if (i_y_zero_flag !== want.flag) report("y zero flag", i_y_zero_flag, want.flag);
            end
        end
        o_pending <= pointing_q.size();
    end

endmodule

// ===== tb/testbench.sv =====
// Top of the pointing transform bench. It makes stimulus, drives both
// handshakes with random idling, and gives the verdict; the checker beside
// the block predicts every result and counts mismatches.
module testbench;

    localparam int N_RANDOM    = 800;
    localparam int CYCLE_LIMIT = 500000;
    // Drain well past the pipeline depth.
    localparam int DRAIN       = 80;

    logic               i_clk = 0;
    logic               i_rst_n = 0;
    logic               i_valid = 0;
    logic               i_stall = 0;
    logic               o_stall;
    logic               o_valid;
    logic signed [15:0] i_yaw_cdeg = '0;
    logic signed [14:0] i_pitch_cdeg = '0;
    logic signed [15:0] i_roll_cdeg = '0;
    logic signed [16:0] i_axis_az_cdeg = '0;
    logic signed [14:0] i_mirror_el_cdeg = '0;
    logic signed [14:0] o_space_az_cdeg;
    logic signed [14:0] o_space_el_cdeg;
    logic               o_y_zero_flag;
    int                 mismatches;
    int                 outstanding;
    int                 cycles = 0;
    bit                 sender_bursty = 0;
    bit                 receiver_bursty = 0;

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    gimbal_pointing_angle_transform i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_yaw_cdeg       (i_yaw_cdeg),
        .i_pitch_cdeg     (i_pitch_cdeg),
        .i_roll_cdeg      (i_roll_cdeg),
        .i_axis_az_cdeg   (i_axis_az_cdeg),
        .i_mirror_el_cdeg (i_mirror_el_cdeg),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_space_az_cdeg  (o_space_az_cdeg),
        .o_space_el_cdeg  (o_space_el_cdeg),
        .o_y_zero_flag    (o_y_zero_flag)
    );

    pointing_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_yaw_cdeg       (i_yaw_cdeg),
        .i_pitch_cdeg     (i_pitch_cdeg),
        .i_roll_cdeg      (i_roll_cdeg),
        .i_axis_az_cdeg   (i_axis_az_cdeg),
        .i_mirror_el_cdeg (i_mirror_el_cdeg),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_space_az_cdeg  (o_space_az_cdeg),
        .i_space_el_cdeg  (o_space_el_cdeg),
        .i_y_zero_flag    (o_y_zero_flag),
        .o_errors         (mismatches),
        .o_pending        (outstanding)
    );

    // Offer one beat. A gap, when drawn, drops valid for that many cycles first;
    // with no gap the payload changes under a valid that simply stays high, so
    // valid is never lowered and raised in the same step.
    task automatic offer_beat(int yaw, int pit, int rol, int az, int mir);
        int gap;
        gap = sender_bursty ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1;
        i_yaw_cdeg       <= 16'(yaw);
        i_pitch_cdeg     <= 15'(pit);
        i_roll_cdeg      <= 16'(rol);
        i_axis_az_cdeg   <= 17'(az);
        i_mirror_el_cdeg <= 15'(mir);
        // The beat is taken at the first edge where the block is not stalling.
        do @(posedge i_clk); while (o_stall);
    endtask

    // Each field is drawn either within its meaningful span or as a raw bit
    // pattern, since any pattern is legal and must wrap modulo a full turn.
    task automatic offer_random_beat();
        int yaw, pit, rol, az, mir;
        if ($urandom_range(0, 3) != 0) begin
            yaw = $urandom_range(0, 36000) - 18000;
            pit = $urandom_range(0, 18000) - 9000;
            rol = $urandom_range(0, 36000) - 18000;
            az  = $urandom_range(0, 72000) - 36000;
            mir = $urandom_range(0, 18000) - 9000;
        end else begin
            yaw = $signed(16'($urandom()));
            pit = $signed(15'($urandom()));
            rol = $signed(16'($urandom()));
            az  = $signed(17'($urandom()));
            mir = $signed(15'($urandom()));
        end
        offer_beat(yaw, pit, rol, az, mir);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed beats: a level platform first, then the extremes of every
        // field, both in range and at the limits of their bit widths.
        offer_beat(0, 0, 0, 0, 0);
        offer_beat(18000, 9000, 18000, 36000, 9000);
        offer_beat(-18000, -9000, -18000, -36000, -9000);
        offer_beat(32767, 16383, 32767, 65535, 16383);
        offer_beat(-32768, -16384, -32768, -65536, -16384);
        offer_beat(9000, 0, 0, 9000, 0);
        offer_beat(0, 0, 9000, -9000, 0);
        offer_beat(0, 4500, 0, 18000, 2000);
        // A beam tilted to 105 or -75 degrees lands on the vertical once the
        // fixed 15 degree tilt is applied: y, and possibly the whole
        // horizontal magnitude, comes out zero or nearly so.
        offer_beat(0, 0, 0, 0, 4500);
        offer_beat(0, 0, 0, 0, -4500);
        offer_beat(0, 0, 0, 18000, 4500);
        offer_beat(0, 0, 0, 9000, 4500);
        offer_beat(18000, 0, 0, 0, 4500);
        offer_beat(0, 0, 0, 0, 4499);
        offer_beat(0, 0, 0, 0, 4501);
        // An attitude that turns the beam level along x, so y vanishes.
        offer_beat(9000, 0, 0, 0, -750);
        offer_beat(-9000, 0, 0, 0, -750);
        offer_beat(0, 0, 0, 9000, -750);
        offer_beat(0, 0, 0, -9000, -750);
        offer_beat(1, -1, 1, -1, 1);

        // Random part in blocks of fifty, each drawn dense or gappy at random
        // so that both regimes meet every phase of the pipeline.
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 50 == 0) sender_bursty = ($urandom_range(0, 2) == 0);
            offer_random_beat();
        end
        i_valid <= 0;

        wait (outstanding == 0);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Receiver: stall for a drawn number of cycles before each result beat.
    // Around the three hundredth beat it holds off for a long stretch while
    // the sender keeps offering, so the pipeline fills and stalls its input.
    initial begin
        int wait_cycles;
        int taken;
        taken = 0;
        forever begin
            if (taken % 50 == 0) receiver_bursty = ($urandom_range(0, 2) == 0);
            wait_cycles = receiver_bursty ? 0 : $urandom_range(0, 16);
            if (taken == 300) wait_cycles = 600;
            if (wait_cycles > 0) begin
                i_stall <= 1;
                repeat (wait_cycles) @(posedge i_clk);
                i_stall <= 0;
            end
            do @(posedge i_clk); while (!(o_valid && i_rst_n));
            taken++;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
design/gpat_pkg.sv
design/gpat_rot_cell.sv
design/gpat_vec_cell.sv
design/gimbal_pointing_angle_transform.sv
tb/pointing_checker.sv
tb/testbench.sv
